>>> hw/rtl/bvm_pkg.sv
`timescale 1ns / 1ps
package bvm_pkg;
  localparam int MEM_ADDR_BITS = 16;
  localparam int NUM_REGS = 16;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_EXEC = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_ILLEGAL = 2'd1;
  localparam logic [1:0] FAULT_DIV0 = 2'd2;

  localparam logic [7:0] OP_NOP = 8'h00;
  localparam logic [7:0] OP_MOV = 8'h01;
  localparam logic [7:0] OP_LDI = 8'h02;
  localparam logic [7:0] OP_STA = 8'h03;
  localparam logic [7:0] OP_LDA = 8'h04;
  localparam logic [7:0] OP_LDW = 8'h05;
  localparam logic [7:0] OP_STPI = 8'h06;
  localparam logic [7:0] OP_STPR = 8'h07;
  localparam logic [7:0] OP_LDP = 8'h08;
  localparam logic [7:0] OP_HALT = 8'h09;
  localparam logic [7:0] OP_ADD = 8'h0A;
  localparam logic [7:0] OP_SUB = 8'h0B;
  localparam logic [7:0] OP_INC = 8'h0C;
  localparam logic [7:0] OP_DEC = 8'h0D;
  localparam logic [7:0] OP_CMP = 8'h0E;
  localparam logic [7:0] OP_CMPI = 8'h0F;
  localparam logic [7:0] OP_JMP = 8'h10;
  localparam logic [7:0] OP_JZ = 8'h11;
  localparam logic [7:0] OP_JNZ = 8'h12;
  localparam logic [7:0] OP_JP = 8'h13;
  localparam logic [7:0] OP_JPZ = 8'h14;
  localparam logic [7:0] OP_JPNZ = 8'h15;
  localparam logic [7:0] OP_CALL = 8'h16;
  localparam logic [7:0] OP_CALLP = 8'h17;
  localparam logic [7:0] OP_RET = 8'h18;
  localparam logic [7:0] OP_PUSH = 8'h19;
  localparam logic [7:0] OP_POP = 8'h1A;
  localparam logic [7:0] OP_PUSHI = 8'h1B;
  localparam logic [7:0] OP_AND = 8'h1C;
  localparam logic [7:0] OP_OR = 8'h1D;
  localparam logic [7:0] OP_XOR = 8'h1E;
  localparam logic [7:0] OP_MUL = 8'h1F;
  localparam logic [7:0] OP_SYS = 8'h20;
  localparam logic [7:0] OP_DIV = 8'h21;
  localparam logic [7:0] OP_MULI = 8'h22;
  localparam logic [7:0] OP_DIVI = 8'h23;
  localparam logic [7:0] OP_MOD = 8'h24;
  localparam logic [7:0] OP_MODI = 8'h25;

  typedef struct packed {
    logic [7:0] read_data;
    logic [15:0] pc_now;
    logic halted;
    logic out_valid;
    logic out_kind;
    logic [7:0] out_value;
    logic in_used;
    logic [1:0] fault;
  } result_t;
endpackage

>>> hw/rtl/bvm_ram.sv
`timescale 1ns / 1ps
module bvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> hw/rtl/bvm_div.sv
`timescale 1ns / 1ps
module bvm_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic busy,
  output logic [7:0] quotient,
  output logic [7:0] remainder
);
  logic [3:0] count;
  logic [8:0] diff;
  logic [8:0] shifted;

  assign shifted = {remainder, quotient[7]};
  assign diff = shifted - {1'b0, divisor};

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 4'd8;
      quotient <= dividend;
      remainder <= 8'd0;
    end else if (busy) begin
      if (diff[8]) begin
        remainder <= shifted[7:0];
        quotient <= {quotient[6:0], 1'b0};
      end else begin
        remainder <= diff[7:0];
        quotient <= {quotient[6:0], 1'b1};
      end
      count <= count - 4'd1;
      if (count == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

>>> hw/rtl/byte_vm_instruction_step.sv
`timescale 1ns / 1ps
// Channel   Dir  Beat contents
// s_axis    in   tdata: cmd, mem_addr, mem_data, console_in
// m_axis    out  tdata: read_data, pc_now, halted, out_valid, out_kind,
//                out_value, in_used, fault
// A load writes the addressed byte and a read fetches it. An instruction
// fetches its opcode and register byte, then decodes; each further byte read
// (immediates, stack and data) adds a memory access and a sequencer step, and
// the second push of a call adds a step; divide and mod by a non-zero divisor
// wait for the bit-serial divider. The single-port main memory sets this order.
// Reset clears registers, pc, sp and flag; memory contents are undefined.
// One item is in flight; a result held on m_axis blocks the next beat.
module byte_vm_instruction_step #(
  parameter int MEM_ADDR_BITS = bvm_pkg::MEM_ADDR_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [39:0] s_axis_tdata, // cmd, mem_addr, mem_data, console_in
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // read_data, pc_now, halted, out_valid, out_kind, out_value, in_used, fault
  output logic [39:0] m_axis_tdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_MRD, S_MWAIT, S_DIV, S_DIVWAIT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    R_OP, R_RB, R_IMM, R_HI, R_LO, R_DATA, R_HOST
  } rd_t;

  state_t state;
  rd_t rtag;
  logic [1:0] cmd;
  logic [7:0] cin;
  logic [7:0] regs [bvm_pkg::NUM_REGS];
  logic [15:0] pc, sp;
  logic zf;
  logic [7:0] op, rb, imm, hi8;
  logic [3:0] st_step;
  bvm_pkg::result_t res;

  logic we;
  logic [MEM_ADDR_BITS-1:0] maddr;
  logic [7:0] wdata, rdata;
  logic [15:0] acc_addr;

  logic div_start, div_busy;
  logic [7:0] quo, rem, div_a, div_b;

  logic [3:0] rd_i, rs_i;
  logic [7:0] vd, vs;
  logic [15:0] pair;
  logic [15:0] mul;

  assign rd_i = rb[7:4];
  assign rs_i = rb[3:0];
  assign vd = regs[rd_i];
  assign vs = regs[rs_i];
  assign pair = {vd, vs};
  assign mul = vd * (op == bvm_pkg::OP_MULI ? imm : vs);
  assign maddr = acc_addr[MEM_ADDR_BITS-1:0];

  bvm_ram #(.WIDTH(8), .DEPTH(2 ** MEM_ADDR_BITS)) u_mem (
    .clk(clk), .we(we), .addr(maddr), .wdata(wdata), .rdata(rdata)
  );

  bvm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(quo), .remainder(rem)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  // pc holds still while the result waits
  assign m_axis_tdata = {2'b00, res.fault, res.in_used, res.out_value, res.out_kind,
                         res.out_valid, res.halted, pc, res.read_data};

  // command and instruction state machine; decode runs once the opcode and register byte are in
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= 16'd0;
      sp <= 16'd0;
      zf <= 1'b0;
      we <= 1'b0;
      div_start <= 1'b0;
      for (int i = 0; i < bvm_pkg::NUM_REGS; i++) begin
        regs[i] <= 8'd0;
      end
    end else begin
      we <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd <= s_axis_tdata[1:0];
            cin <= s_axis_tdata[33:26];
            res <= '0;
            st_step <= 4'd0;
            case (s_axis_tdata[1:0])
              bvm_pkg::CMD_LOAD: begin
                acc_addr <= s_axis_tdata[17:2];
                wdata <= s_axis_tdata[25:18];
                we <= 1'b1;
                state <= S_MWAIT;
                rtag <= R_HOST;
              end
              bvm_pkg::CMD_READ: begin
                acc_addr <= s_axis_tdata[17:2];
                rtag <= R_DATA;
                state <= S_MRD;
              end
              bvm_pkg::CMD_EXEC: begin
                acc_addr <= pc;
                pc <= pc + 16'd1;
                rtag <= R_OP;
                state <= S_MRD;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_MRD: state <= S_MWAIT;
        S_MWAIT: begin
          state <= S_MRD;
          if (cmd == bvm_pkg::CMD_LOAD) begin
            state <= S_OUT;
          end else if (cmd == bvm_pkg::CMD_READ) begin
            res.read_data <= rdata;
            state <= S_OUT;
          end else begin
            // execute: rtag says which byte has just come back
            case (rtag)
              R_OP: begin
                op <= rdata;
                acc_addr <= pc;
                pc <= pc + 16'd1;
                rtag <= R_RB;
              end
              R_RB: begin
                rb <= rdata;
                rtag <= R_IMM;
                state <= S_DIV; // decode cycle
                st_step <= 4'd0;
              end
              R_IMM: begin
                imm <= rdata;
                st_step <= st_step + 4'd1;
                state <= S_DIV;
              end
              R_HI: begin
                hi8 <= rdata;
                st_step <= st_step + 4'd1;
                state <= S_DIV;
              end
              default: begin
                hi8 <= rdata; // data byte
                st_step <= st_step + 4'd1;
                state <= S_DIV;
              end
            endcase
          end
        end
        S_DIV: begin
          // sequencer: st_step counts completed accesses after fetch
          state <= S_MRD;
          case (op)
            bvm_pkg::OP_NOP: state <= S_OUT;
            bvm_pkg::OP_MOV: begin regs[rd_i] <= vs; state <= S_OUT; end
            bvm_pkg::OP_HALT: begin res.halted <= 1'b1; state <= S_OUT; end
            bvm_pkg::OP_ADD, bvm_pkg::OP_SUB, bvm_pkg::OP_INC, bvm_pkg::OP_DEC: begin
              logic [7:0] t;
              case (op)
                bvm_pkg::OP_ADD: t = vd + vs;
                bvm_pkg::OP_SUB: t = vd - vs;
                bvm_pkg::OP_INC: t = vd + 8'd1;
                default: t = vd - 8'd1;
              endcase
              regs[rd_i] <= t;
              zf <= (t == 8'd0);
              state <= S_OUT;
            end
            bvm_pkg::OP_CMP: begin zf <= (vd == vs); state <= S_OUT; end
            bvm_pkg::OP_AND: begin regs[rd_i] <= vd & vs; state <= S_OUT; end
            bvm_pkg::OP_OR: begin regs[rd_i] <= vd | vs; state <= S_OUT; end
            bvm_pkg::OP_XOR: begin regs[rd_i] <= vd ^ vs; state <= S_OUT; end
            bvm_pkg::OP_MUL: begin regs[rd_i] <= mul[7:0]; state <= S_OUT; end
            bvm_pkg::OP_JP: begin pc <= pair; state <= S_OUT; end
            bvm_pkg::OP_JPZ: begin if (zf) pc <= pair; state <= S_OUT; end
            bvm_pkg::OP_JPNZ: begin if (!zf) pc <= pair; state <= S_OUT; end
            bvm_pkg::OP_LDI, bvm_pkg::OP_CMPI, bvm_pkg::OP_MULI, bvm_pkg::OP_STPI,
            bvm_pkg::OP_STPR, bvm_pkg::OP_LDP, bvm_pkg::OP_PUSHI, bvm_pkg::OP_SYS,
            bvm_pkg::OP_DIVI, bvm_pkg::OP_MODI: begin
              if (st_step == 4'd0) begin
                acc_addr <= pc;
                pc <= pc + 16'd1;
                rtag <= R_IMM;
              end else begin
                case (op)
                  bvm_pkg::OP_LDI: begin regs[rd_i] <= imm; state <= S_OUT; end
                  bvm_pkg::OP_CMPI: begin zf <= (vd == imm); state <= S_OUT; end
                  bvm_pkg::OP_MULI: begin regs[rd_i] <= mul[7:0]; state <= S_OUT; end
                  bvm_pkg::OP_STPI, bvm_pkg::OP_STPR: begin
                    acc_addr <= pair;
                    wdata <= (op == bvm_pkg::OP_STPI) ? imm : regs[imm[3:0]];
                    we <= 1'b1;
                    state <= S_OUT;
                  end
                  bvm_pkg::OP_LDP: begin
                    if (st_step == 4'd1) begin
                      acc_addr <= pair;
                      rtag <= R_DATA;
                    end else begin
                      regs[imm[3:0]] <= hi8;
                      state <= S_OUT;
                    end
                  end
                  bvm_pkg::OP_PUSHI: begin
                    acc_addr <= sp;
                    wdata <= imm;
                    we <= 1'b1;
                    sp <= sp - 16'd1;
                    state <= S_OUT;
                  end
                  bvm_pkg::OP_SYS: begin
                    state <= S_OUT;
                    case (imm)
                      8'd1, 8'd5: begin
                        res.in_used <= 1'b1;
                        acc_addr <= sp;
                        wdata <= cin;
                        we <= 1'b1;
                        sp <= sp - 16'd1;
                      end
                      8'd3, 8'd7: begin
                        res.in_used <= 1'b1;
                        acc_addr <= pair;
                        wdata <= cin;
                        we <= 1'b1;
                      end
                      8'd0, 8'd4, 8'd2, 8'd6: begin
                        if (st_step == 4'd1) begin
                          state <= S_MRD;
                          rtag <= R_DATA;
                          if (imm[1]) begin
                            acc_addr <= pair;
                          end else begin
                            acc_addr <= sp + 16'd1;
                            sp <= sp + 16'd1;
                          end
                        end else begin
                          res.out_valid <= 1'b1;
                          res.out_kind <= imm[2];
                          res.out_value <= hi8;
                        end
                      end
                      default: ;
                    endcase
                  end
                  default: begin
                    // divide or mod by immediate
                    if (imm == 8'd0) begin
                      res.fault <= bvm_pkg::FAULT_DIV0;
                      state <= S_OUT;
                    end else begin
                      div_a <= vd;
                      div_b <= imm;
                      div_start <= 1'b1;
                      state <= S_DIVWAIT;
                    end
                  end
                endcase
              end
            end
            bvm_pkg::OP_DIV, bvm_pkg::OP_MOD: begin
              if (vs == 8'd0) begin
                res.fault <= bvm_pkg::FAULT_DIV0;
                state <= S_OUT;
              end else begin
                div_a <= vd;
                div_b <= vs;
                div_start <= 1'b1;
                state <= S_DIVWAIT;
              end
            end
            bvm_pkg::OP_STA, bvm_pkg::OP_LDA, bvm_pkg::OP_LDW, bvm_pkg::OP_JMP,
            bvm_pkg::OP_JZ, bvm_pkg::OP_JNZ, bvm_pkg::OP_CALL: begin
              // fetch the 16-bit immediate, high byte first
              case (st_step)
                4'd0: begin acc_addr <= pc; pc <= pc + 16'd1; rtag <= R_HI; end
                4'd1: begin acc_addr <= pc; pc <= pc + 16'd1; rtag <= R_IMM; end
                default: begin
                  case (op)
                    bvm_pkg::OP_STA: begin
                      acc_addr <= {hi8, imm};
                      wdata <= vs;
                      we <= 1'b1;
                      state <= S_OUT;
                    end
                    bvm_pkg::OP_LDA: begin
                      if (st_step == 4'd2) begin
                        acc_addr <= {hi8, imm};
                        rtag <= R_DATA;
                      end else begin
                        regs[rd_i] <= hi8;
                        state <= S_OUT;
                      end
                    end
                    bvm_pkg::OP_LDW: begin
                      regs[rs_i] <= imm;
                      regs[rd_i] <= hi8;
                      state <= S_OUT;
                    end
                    bvm_pkg::OP_JMP: begin pc <= {hi8, imm}; state <= S_OUT; end
                    bvm_pkg::OP_JZ: begin if (zf) pc <= {hi8, imm}; state <= S_OUT; end
                    bvm_pkg::OP_JNZ: begin
                      if (!zf) pc <= {hi8, imm};
                      state <= S_OUT;
                    end
                    default: begin
                      // call: push pc high then low, one write a cycle
                      if (st_step == 4'd2) begin
                        acc_addr <= sp;
                        wdata <= pc[15:8];
                        we <= 1'b1;
                        sp <= sp - 16'd1;
                        st_step <= 4'd3;
                        state <= S_DIV;
                      end else begin
                        acc_addr <= sp;
                        wdata <= pc[7:0];
                        we <= 1'b1;
                        sp <= sp - 16'd1;
                        pc <= {hi8, imm};
                        state <= S_OUT;
                      end
                    end
                  endcase
                end
              endcase
            end
            bvm_pkg::OP_CALLP: begin
              acc_addr <= sp;
              we <= 1'b1;
              sp <= sp - 16'd1;
              if (st_step == 4'd0) begin
                wdata <= pc[15:8];
                st_step <= 4'd1;
                state <= S_DIV;
              end else begin
                wdata <= pc[7:0];
                pc <= pair;
                state <= S_OUT;
              end
            end
            bvm_pkg::OP_PUSH: begin
              acc_addr <= sp;
              wdata <= vs;
              we <= 1'b1;
              sp <= sp - 16'd1;
              state <= S_OUT;
            end
            bvm_pkg::OP_POP: begin
              if (st_step == 4'd0) begin
                acc_addr <= sp + 16'd1;
                sp <= sp + 16'd1;
                rtag <= R_DATA;
              end else begin
                regs[rd_i] <= hi8;
                state <= S_OUT;
              end
            end
            bvm_pkg::OP_RET: begin
              case (st_step)
                4'd0, 4'd1: begin
                  if (st_step == 4'd1) imm <= hi8;
                  acc_addr <= sp + 16'd1;
                  sp <= sp + 16'd1;
                  rtag <= R_DATA;
                end
                default: begin pc <= {hi8, imm}; state <= S_OUT; end
              endcase
            end
            default: begin
              res.fault <= bvm_pkg::FAULT_ILLEGAL;
              state <= S_OUT;
            end
          endcase
        end
        S_DIVWAIT: begin
          if (!div_busy && !div_start) begin
            if (op == bvm_pkg::OP_DIV || op == bvm_pkg::OP_DIVI) begin
              regs[rd_i] <= quo;
            end else begin
              zf <= (rem == 8'd0);
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bvm_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  cin;
  } vm_item_t;

  typedef struct {
    logic [7:0]  read_data;
    logic [15:0] pc_now;
    logic        halted;
    logic        out_valid;
    logic        out_kind;
    logic [7:0]  out_value;
    logic        in_used;
    logic [1:0]  fault;
  } vm_res_t;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [39:0] m_axis_tdata;

  byte_vm_instruction_step dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // shadow machine state
  logic [7:0]  shadow_mem [65536];
  bit          mem_written [65536];
  logic [7:0]  shadow_regs [16];
  logic [15:0] shadow_pc;
  logic [15:0] shadow_sp;
  logic        shadow_zf;

  logic [39:0] pending_beats [$];
  vm_res_t     expected_results [$];
  int errors;
  int n_exec;
  int n_faults;
  int n_prints;
  int cycles;
  bit stim_done;

  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b = shadow_mem[shadow_pc];
    shadow_pc = shadow_pc + 16'd1;
    return b;
  endfunction

  function automatic void push_byte(logic [7:0] v);
    shadow_mem[shadow_sp] = v;
    mem_written[shadow_sp] = 1;
    shadow_sp = shadow_sp - 16'd1;
  endfunction

  function automatic logic [7:0] pop_byte();
    shadow_sp = shadow_sp + 16'd1;
    return shadow_mem[shadow_sp];
  endfunction

  function automatic void mem_store(logic [15:0] a, logic [7:0] v);
    shadow_mem[a] = v;
    mem_written[a] = 1;
  endfunction

  function automatic int imm_bytes(logic [7:0] op);
    case (op)
      OP_LDI, OP_STPI, OP_STPR, OP_LDP, OP_CMPI, OP_PUSHI, OP_SYS, OP_MULI, OP_DIVI,
      OP_MODI: return 1;
      OP_STA, OP_LDA, OP_LDW, OP_JMP, OP_JZ, OP_JNZ, OP_CALL: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic vm_res_t vm_step(vm_item_t it);
    vm_res_t r;
    logic [7:0] op, rb, vs, b, lo, hi;
    logic [3:0] d, s;
    logic [15:0] pair, w;
    r = '{default: '0};
    if (it.cmd == CMD_LOAD) begin
      mem_store(it.addr, it.data);
    end else if (it.cmd == CMD_READ) begin
      r.read_data = shadow_mem[it.addr];
    end else if (it.cmd == CMD_EXEC) begin
      op = fetch_byte();
      rb = fetch_byte();
      d = rb[7:4];
      s = rb[3:0];
      vs = shadow_regs[s];
      pair = {shadow_regs[d], vs};
      case (op)
        OP_NOP: ;
        OP_MOV: shadow_regs[d] = vs;
        OP_LDI: shadow_regs[d] = fetch_byte();
        OP_STA: begin w[15:8] = fetch_byte(); w[7:0] = fetch_byte(); mem_store(w, vs); end
        OP_LDA: begin
          w[15:8] = fetch_byte(); w[7:0] = fetch_byte(); shadow_regs[d] = shadow_mem[w];
        end
        OP_LDW: begin
          w[15:8] = fetch_byte(); w[7:0] = fetch_byte();
          shadow_regs[s] = w[7:0];
          shadow_regs[d] = w[15:8];
        end
        OP_STPI: begin b = fetch_byte(); mem_store(pair, b); end
        OP_STPR: begin b = fetch_byte(); mem_store(pair, shadow_regs[b[3:0]]); end
        OP_LDP: begin b = fetch_byte(); shadow_regs[b[3:0]] = shadow_mem[pair]; end
        OP_HALT: r.halted = 1;
        OP_ADD: begin
          shadow_regs[d] = shadow_regs[d] + vs; shadow_zf = (shadow_regs[d] == 0);
        end
        OP_SUB: begin
          shadow_regs[d] = shadow_regs[d] - vs; shadow_zf = (shadow_regs[d] == 0);
        end
        OP_INC: begin
          shadow_regs[d] = shadow_regs[d] + 8'd1; shadow_zf = (shadow_regs[d] == 0);
        end
        OP_DEC: begin
          shadow_regs[d] = shadow_regs[d] - 8'd1; shadow_zf = (shadow_regs[d] == 0);
        end
        OP_CMP: shadow_zf = (shadow_regs[d] == vs);
        OP_CMPI: begin b = fetch_byte(); shadow_zf = (shadow_regs[d] == b); end
        OP_JMP: begin w[15:8] = fetch_byte(); w[7:0] = fetch_byte(); shadow_pc = w; end
        OP_JZ: begin
          w[15:8] = fetch_byte(); w[7:0] = fetch_byte(); if (shadow_zf) shadow_pc = w;
        end
        OP_JNZ: begin
          w[15:8] = fetch_byte(); w[7:0] = fetch_byte(); if (!shadow_zf) shadow_pc = w;
        end
        OP_JP: shadow_pc = pair;
        OP_JPZ: if (shadow_zf) shadow_pc = pair;
        OP_JPNZ: if (!shadow_zf) shadow_pc = pair;
        OP_CALL: begin
          w[15:8] = fetch_byte(); w[7:0] = fetch_byte();
          push_byte(shadow_pc[15:8]); push_byte(shadow_pc[7:0]);
          shadow_pc = w;
        end
        OP_CALLP: begin
          push_byte(shadow_pc[15:8]); push_byte(shadow_pc[7:0]);
          shadow_pc = pair;
        end
        OP_RET: begin lo = pop_byte(); hi = pop_byte(); shadow_pc = {hi, lo}; end
        OP_PUSH: push_byte(vs);
        OP_POP: shadow_regs[d] = pop_byte();
        OP_PUSHI: push_byte(fetch_byte());
        OP_AND: shadow_regs[d] = shadow_regs[d] & vs;
        OP_OR: shadow_regs[d] = shadow_regs[d] | vs;
        OP_XOR: shadow_regs[d] = shadow_regs[d] ^ vs;
        OP_MUL: shadow_regs[d] = shadow_regs[d] * vs;
        OP_SYS: begin
          b = fetch_byte();
          case (b)
            8'd0, 8'd4: begin r.out_valid = 1; r.out_kind = b[2]; r.out_value = pop_byte(); end
            8'd2, 8'd6: begin
              r.out_valid = 1; r.out_kind = b[2]; r.out_value = shadow_mem[pair];
            end
            8'd1, 8'd5: begin r.in_used = 1; push_byte(it.cin); end
            8'd3, 8'd7: begin r.in_used = 1; mem_store(pair, it.cin); end
            default: ;
          endcase
        end
        OP_DIV: if (vs == 0) r.fault = FAULT_DIV0; else shadow_regs[d] = shadow_regs[d] / vs;
        OP_MULI: begin b = fetch_byte(); shadow_regs[d] = shadow_regs[d] * b; end
        OP_DIVI: begin
          b = fetch_byte();
          if (b == 0) r.fault = FAULT_DIV0; else shadow_regs[d] = shadow_regs[d] / b;
        end
        OP_MOD: if (vs == 0) r.fault = FAULT_DIV0;
                else shadow_zf = ((shadow_regs[d] % vs) == 0);
        OP_MODI: begin
          b = fetch_byte();
          if (b == 0) r.fault = FAULT_DIV0; else shadow_zf = ((shadow_regs[d] % b) == 0);
        end
        default: r.fault = FAULT_ILLEGAL;
      endcase
    end
    r.pc_now = shadow_pc;
    return r;
  endfunction

  function automatic void add_item(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
    vm_item_t it;
    vm_res_t r;
    it.cmd = cmd;
    it.addr = addr;
    it.data = data;
    it.cin = 8'($urandom);
    r = vm_step(it);
    if (cmd == CMD_EXEC) begin
      n_exec++;
      if (r.fault != FAULT_NONE) n_faults++;
      if (r.out_valid) n_prints++;
    end
    pending_beats.push_back({6'd0, it.cin, it.data, it.addr, it.cmd});
    expected_results.push_back(r);
  endfunction

  // load a random byte where the next instruction would read unwritten memory
  function automatic void fill_if_blank(logic [15:0] a);
    if (!mem_written[a]) add_item(CMD_LOAD, a, 8'($urandom));
  endfunction

  function automatic logic [7:0] pick_imm(logic [7:0] op, int k);
    if (op == OP_SYS) return 8'($urandom_range(0, 9));
    if ((op == OP_DIVI || op == OP_MODI) && $urandom_range(0, 3) == 0) return 8'd0;
    if ((op == OP_STPR || op == OP_LDP) && $urandom_range(0, 1) == 0) return 8'($urandom);
    return 8'($urandom);
  endfunction

  // place an instruction at pc (unless reusing code already there), then run it
  function automatic void run_instr(logic [7:0] op, bit reuse);
    logic [15:0] p, pair, w;
    logic [7:0] cur_op, rb;
    int n;
    p = shadow_pc;
    if (!reuse) begin
      add_item(CMD_LOAD, p, op);
      add_item(CMD_LOAD, p + 16'd1, 8'($urandom));
      for (int k = 0; k < imm_bytes(op); k++)
        add_item(CMD_LOAD, p + 16'(2 + k), pick_imm(op, k));
    end
    fill_if_blank(p);
    fill_if_blank(p + 16'd1);
    cur_op = shadow_mem[p];
    rb = shadow_mem[p + 16'd1];
    n = imm_bytes(cur_op);
    for (int k = 0; k < n; k++) fill_if_blank(p + 16'(2 + k));
    pair = {shadow_regs[rb[7:4]], shadow_regs[rb[3:0]]};
    w = {shadow_mem[p + 16'd2], shadow_mem[p + 16'd3]};
    case (cur_op)
      OP_LDA: fill_if_blank(w);
      OP_LDP: fill_if_blank(pair);
      OP_POP: fill_if_blank(shadow_sp + 16'd1);
      OP_RET: begin fill_if_blank(shadow_sp + 16'd1); fill_if_blank(shadow_sp + 16'd2); end
      OP_SYS: case (shadow_mem[p + 16'd2])
        8'd0, 8'd4: fill_if_blank(shadow_sp + 16'd1);
        8'd2, 8'd6: fill_if_blank(pair);
        default: ;
      endcase
      default: ;
    endcase
    add_item(CMD_EXEC, 16'($urandom), 8'($urandom));
  endfunction

  function automatic logic [7:0] random_op();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 8'($urandom_range(8'h26, 8'hFF));
    if (sel < 4) return OP_LDI;
    return 8'($urandom_range(0, 8'h25));
  endfunction

  function automatic void load_random_written_read();
    int idx;
    logic [15:0] a;
    a = 16'($urandom);
    for (idx = 0; idx < 64 && !mem_written[a]; idx++) a = a + 16'd1;
    if (mem_written[a]) add_item(CMD_READ, a, 8'($urandom));
    else add_item(CMD_LOAD, a, 8'($urandom));
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    int sel;
    errors = 0; n_exec = 0; n_faults = 0; n_prints = 0; stim_done = 0;
    for (int i = 0; i < 16; i++) shadow_regs[i] = 8'd0;
    shadow_pc = 16'd0;
    shadow_sp = 16'd0;
    shadow_zf = 1'b0;
    rst = 1;
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: address and data extremes, unused command, faults, halt
    add_item(CMD_LOAD, 16'hFFFF, 8'hFF);
    add_item(CMD_LOAD, 16'h8000, 8'h00);
    add_item(CMD_READ, 16'hFFFF, 8'h00);
    add_item(CMD_READ, 16'h8000, 8'hFF);
    add_item(CMD_NONE, 16'hFFFF, 8'hFF);
    run_instr(OP_HALT, 0);
    run_instr(OP_DIV, 0);
    run_instr(8'hFF, 0);
    run_instr(OP_SYS, 0);
    run_instr(OP_RET, 0);

    // every opcode once, then random programs
    for (int i = 0; i <= 8'h25; i++) run_instr(8'(i), 0);
    while (pending_beats.size() < 560) begin
      sel = $urandom_range(0, 19);
      if (sel < 13) run_instr(random_op(), 0);
      else if (sel < 16 && mem_written[shadow_pc] && mem_written[shadow_pc + 16'd1])
        run_instr(8'd0, 1);
      else if (sel < 18) load_random_written_read();
      else if (sel == 18) add_item(CMD_LOAD, 16'($urandom), 8'($urandom));
      else add_item(CMD_NONE, 16'($urandom), 8'($urandom));
    end
    stim_done = 1;

    wait (stim_done && pending_beats.size() == 0 && expected_results.size() == 0);
    repeat (50) @(posedge clk);
    $display("Ran %0d instructions (%0d faults, %0d console prints) with loads and reads",
             n_exec, n_faults, n_prints);
    $display("under random source gaps and sink stalls; %0d mismatches", errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // driver: bursts with random gaps
  int gap_left;
  int burst_left;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
      s_axis_tdata <= '0;
      gap_left <= 0;
      burst_left <= 4;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 0;
        gap_left <= gap_left - 1;
      end else if (pending_beats.size() > 0) begin
        s_axis_tdata <= pending_beats.pop_front();
        s_axis_tvalid <= 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // sink: alternate free-running stretches and random stalls
  int sink_phase;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
      sink_phase <= 0;
    end else begin
      sink_phase <= (sink_phase + 1) % 200;
      if (sink_phase < 60) m_axis_tready <= 1;
      else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    vm_res_t e;
    vm_res_t a;
    bit bad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      a.read_data = m_axis_tdata[7:0];
      a.pc_now    = m_axis_tdata[23:8];
      a.halted    = m_axis_tdata[24];
      a.out_valid = m_axis_tdata[25];
      a.out_kind  = m_axis_tdata[26];
      a.out_value = m_axis_tdata[34:27];
      a.in_used   = m_axis_tdata[35];
      a.fault     = m_axis_tdata[37:36];
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat %h", $time, m_axis_tdata);
      end else begin
        e = expected_results.pop_front();
        bad = 0;
        if (a.read_data !== e.read_data) begin
          bad = 1;
          $display("%0t: read_data exp %h got %h", $time, e.read_data, a.read_data);
        end
        if (a.pc_now !== e.pc_now) begin
          bad = 1;
          $display("%0t: pc_now exp %h got %h", $time, e.pc_now, a.pc_now);
        end
        if (a.halted !== e.halted) begin
          bad = 1;
          $display("%0t: halted exp %b got %b", $time, e.halted, a.halted);
        end
        if (a.out_valid !== e.out_valid) begin
          bad = 1;
          $display("%0t: out_valid exp %b got %b", $time, e.out_valid, a.out_valid);
        end
        if (a.out_kind !== e.out_kind) begin
          bad = 1;
          $display("%0t: out_kind exp %b got %b", $time, e.out_kind, a.out_kind);
        end
        if (a.out_value !== e.out_value) begin
          bad = 1;
          $display("%0t: out_value exp %h got %h", $time, e.out_value, a.out_value);
        end
        if (a.in_used !== e.in_used) begin
          bad = 1;
          $display("%0t: in_used exp %b got %b", $time, e.in_used, a.in_used);
        end
        if (a.fault !== e.fault) begin
          bad = 1;
          $display("%0t: fault exp %0d got %0d", $time, e.fault, a.fault);
        end
        if (bad) errors++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end
endmodule
